/* hw/rtl/clnws_pkg.sv */
// ----------------------------------------------------------------------------
// Character LCD nibble write sequencer package
// Shared types, register indexes, command codes and init byte table.
// ----------------------------------------------------------------------------
`default_nettype none

package clnws_pkg;

    localparam int WAIT_BITS     = 20;
    localparam int HOLD_SUM_BITS = WAIT_BITS + 2;
    localparam int STEP_BITS     = 5;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [WAIT_BITS-1:0] WAIT_MAX = {WAIT_BITS{1'b1}};

    localparam logic [STEP_BITS-1:0] STEP_BYTE_LAST  = 5'd3;
    localparam logic [STEP_BITS-1:0] STEP_INIT_LAST  = 5'd24;
    localparam logic [STEP_BITS-1:0] STEP_NIBBLE_END = 5'd8;
    localparam logic [STEP_BITS-1:0] STEP_BYTES_BASE = 5'd9;

    localparam logic [7:0] INIT_FUNC_SET  = 8'h28;
    localparam logic [7:0] INIT_DISP_ON   = 8'h0C;
    localparam logic [7:0] INIT_CLEAR     = 8'h01;
    localparam logic [7:0] INIT_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
    localparam logic [3:0] WAKE_NIBBLE    = 4'h3;
    localparam logic [3:0] MODE4_NIBBLE   = 4'h2;

    localparam logic [6:0] LINE1_BASE = 7'h00;
    localparam logic [6:0] LINE2_BASE = 7'h40;
    localparam logic [6:0] LINE3_BASE = 7'h14;
    localparam logic [6:0] LINE4_BASE = 7'h54;

    localparam logic [1:0] CLEAR_BYTE_IDX = 2'd2;

    typedef enum logic [1:0] {
        CMD_INSTR = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_GOTO  = 2'd2,
        CMD_INIT  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ENABLE_TICKS  = 3'd0,
        REG_SETUP_TICKS   = 3'd1,
        REG_POWERUP_TICKS = 3'd2,
        REG_SETTLE_TICKS  = 3'd3,
        REG_CLEAR_TICKS   = 3'd4,
        REG_FOUR_LINE     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] byte_value;
        logic [7:0] line;
        logic [7:0] column;
    } t_in;

    typedef struct packed {
        logic                 register_select;
        logic                 read_write;
        logic [3:0]           data_nibble;
        logic                 enable_level;
        logic [WAIT_BITS-1:0] hold_ticks;
        logic                 last;
    } t_out;

    typedef struct packed {
        logic [WAIT_BITS-1:0] enable_ticks;
        logic [WAIT_BITS-1:0] setup_ticks;
        logic [WAIT_BITS-1:0] powerup_ticks;
        logic [WAIT_BITS-1:0] settle_ticks;
        logic [WAIT_BITS-1:0] clear_ticks;
        logic                 four_line_mode;
    } t_cfg;

    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0: b = INIT_FUNC_SET;
            2'd1: b = INIT_DISP_ON;
            2'd2: b = INIT_CLEAR;
            default: b = INIT_ENTRY;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/clnws_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// Timing and line mode registers, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module clnws_cfg_regs
    import clnws_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [WAIT_BITS-1:0]    i_cfg_wdata,
    output t_cfg                         o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable_ticks   <= WAIT_BITS'(1000);
            r_cfg.setup_ticks    <= WAIT_BITS'(2000);
            r_cfg.powerup_ticks  <= WAIT_BITS'(80000);
            r_cfg.settle_ticks   <= WAIT_BITS'(20000);
            r_cfg.clear_ticks    <= WAIT_BITS'(500000);
            r_cfg.four_line_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ENABLE_TICKS:  r_cfg.enable_ticks   <= i_cfg_wdata;
                REG_SETUP_TICKS:   r_cfg.setup_ticks    <= i_cfg_wdata;
                REG_POWERUP_TICKS: r_cfg.powerup_ticks  <= i_cfg_wdata;
                REG_SETTLE_TICKS:  r_cfg.settle_ticks   <= i_cfg_wdata;
                REG_CLEAR_TICKS:   r_cfg.clear_ticks    <= i_cfg_wdata;
                REG_FOUR_LINE:     r_cfg.four_line_mode <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hw/rtl/clnws_step_gen.sv */
// ----------------------------------------------------------------------------
// Pin state generator
// Maps the held request and its step number to one pin state and hold time.
// ----------------------------------------------------------------------------
`default_nettype none

module clnws_step_gen
    import clnws_pkg::*;
(
    input  wire t_in                   i_req,
    input  wire logic [STEP_BITS-1:0]  i_step,
    input  wire t_cfg                  i_cfg,
    output t_out                       o_out
);

    logic [WAIT_BITS-1:0]     pulse;
    logic [WAIT_BITS-1:0]     extra;
    logic [HOLD_SUM_BITS-1:0] low_sum;
    logic [WAIT_BITS-1:0]     low_hold;
    logic [6:0]               base;
    logic [6:0]               addr;
    logic [7:0]               byte_sel;
    logic [STEP_BITS-1:0]     nib_step;
    logic [STEP_BITS-1:0]     byte_step;
    logic                     idle_state;
    logic                     rs;
    logic                     en;
    logic [3:0]               nib;
    logic                     last;

    assign pulse = (i_cfg.enable_ticks == '0) ? WAIT_BITS'(1) : i_cfg.enable_ticks;

    always_comb begin
        case (i_req.line)
            8'd2:    base = LINE2_BASE;
            8'd3:    base = i_cfg.four_line_mode ? LINE3_BASE : LINE1_BASE;
            8'd4:    base = i_cfg.four_line_mode ? LINE4_BASE : LINE1_BASE;
            default: base = LINE1_BASE;
        endcase
    end

    assign addr      = base + i_req.column[6:0] + 7'h7F;
    assign nib_step  = i_step - 5'd1;
    assign byte_step = i_step - STEP_BYTES_BASE;

    always_comb begin
        rs         = 1'b0;
        en         = 1'b0;
        nib        = 4'h0;
        extra      = '0;
        last       = 1'b0;
        idle_state = 1'b0;
        byte_sel   = i_req.byte_value;
        case (i_req.command)
            CMD_INSTR, CMD_DATA, CMD_GOTO: begin
                rs = (i_req.command == CMD_DATA);
                if (i_req.command == CMD_GOTO) begin
                    byte_sel = CMD_SET_DDRAM | {1'b0, addr};
                end
                en   = !i_step[0];
                nib  = i_step[1] ? byte_sel[3:0] : byte_sel[7:4];
                last = (i_step == STEP_BYTE_LAST);
            end
            CMD_INIT: begin
                if (i_step == '0) begin
                    idle_state = 1'b1;
                end else if (i_step <= STEP_NIBBLE_END) begin
                    en    = !nib_step[0];
                    nib   = (nib_step[2:1] == 2'd3) ? MODE4_NIBBLE : WAKE_NIBBLE;
                    extra = (nib_step[2:1] == 2'd0) ? i_cfg.powerup_ticks
                                                    : i_cfg.settle_ticks;
                end else begin
                    byte_sel = init_byte(byte_step[3:2]);
                    en       = !byte_step[0];
                    nib      = byte_step[1] ? byte_sel[3:0] : byte_sel[7:4];
                    if (byte_step[3:2] == CLEAR_BYTE_IDX && byte_step[1]) begin
                        extra = i_cfg.clear_ticks;
                    end
                end
                last = (i_step == STEP_INIT_LAST);
            end
            default: ;
        endcase
    end

    assign low_sum  = {2'b00, pulse} + {2'b00, i_cfg.setup_ticks} + {2'b00, extra};
    assign low_hold = (low_sum > {2'b00, WAIT_MAX}) ? WAIT_MAX : low_sum[WAIT_BITS-1:0];

    always_comb begin
        o_out.register_select = rs;
        o_out.read_write      = 1'b0;
        o_out.data_nibble     = nib;
        o_out.enable_level    = en;
        o_out.last            = last;
        if (idle_state) begin
            o_out.hold_ticks = i_cfg.powerup_ticks;
        end else if (en) begin
            o_out.hold_ticks = pulse;
        end else begin
            o_out.hold_ticks = low_hold;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/char_lcd_nibble_write_sequencer.sv */
// ----------------------------------------------------------------------------
// Character LCD nibble write sequencer
// Turns LCD requests into bursts of timed pin states for a 4-bit bus.
// ----------------------------------------------------------------------------
// Each request expands into a burst of pin-state beats, one beat per cycle
// while the output is not stalled: 4 beats for an instruction, data or cursor
// request, 25 beats for the power-up sequence, the final beat marked by last.
// The request register feeds a single pin state generator whose step counter
// advances once per cycle while the output is not stalled.
// An accepted request is registered before its first beat reaches the output
// register; the next request is accepted in the same cycle that the previous
// burst's final beat is loaded there, so bursts follow without a gap.
`default_nettype none

module char_lcd_nibble_write_sequencer
    import clnws_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [WAIT_BITS-1:0]    i_cfg_wdata,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire t_in                     i_in_data,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output t_out                         o_out_data
);

    t_cfg                 cfg;
    t_out                 gen;
    t_in                  r_req;
    logic                 r_req_vld;
    logic [STEP_BITS-1:0] r_step;
    t_out                 r_out;
    logic                 r_out_vld;
    logic                 out_free;
    logic                 advance;
    logic                 done;
    logic                 accept_in;

    clnws_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    clnws_step_gen u_gen (
        .i_req  (r_req),
        .i_step (r_step),
        .i_cfg  (cfg),
        .o_out  (gen)
    );

    assign out_free  = !r_out_vld || !i_out_stall;
    assign advance   = r_req_vld && out_free;
    assign done      = advance && gen.last;
    assign o_in_stall = r_req_vld && !done;
    assign accept_in = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_step    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept_in) begin
                r_req_vld <= 1'b1;
                r_step    <= '0;
            end else if (done) begin
                r_req_vld <= 1'b0;
            end else if (advance) begin
                r_step <= r_step + 5'd1;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_req <= i_in_data;
        end
        if (advance) begin
            r_out <= gen;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_INIT_LAST)
        else $error("step counter beyond final pin state");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && !accept_in) |=> !r_req_vld)
        else $error("request still held after its final beat");

    a_accept_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept_in |=> (r_req_vld && r_step == '0))
        else $error("accepted request did not start at its first step");

    a_write_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_out_data.read_write)
        else $error("read strobe driven on the bus");
`endif

endmodule

`default_nettype wire

/* dv/char_lcd_nibble_write_sequencer_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Character LCD nibble write sequencer pin state checker
// Follows the register port and both channels of the sequencer, works out the
// pin state burst each accepted request must produce and compares every
// output beat with it, field by field.
// ----------------------------------------------------------------------------

module char_lcd_nibble_write_sequencer_checker
    import clnws_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [WAIT_BITS-1:0]    i_cfg_wdata,
    input  wire logic                    i_in_valid,
    input  wire logic                    i_in_stall,
    input  t_in                          i_in_data,
    input  wire logic                    i_out_valid,
    input  wire logic                    i_out_stall,
    input  t_out                         i_out_data,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_beats_checked
);

    t_cfg timing_regs;
    t_out expected_pins[$];
    int   mismatch_total = 0;
    int   beats_matched  = 0;

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_beats_checked = 0;
    end

    function automatic void load_reset_timing();
        timing_regs.enable_ticks   = 20'd1000;
        timing_regs.setup_ticks    = 20'd2000;
        timing_regs.powerup_ticks  = 20'd80000;
        timing_regs.settle_ticks   = 20'd20000;
        timing_regs.clear_ticks    = 20'd500000;
        timing_regs.four_line_mode = 1'b0;
    endfunction

    function automatic void write_timing_reg(logic [CFG_IDX_BITS-1:0] idx,
                                             logic [WAIT_BITS-1:0] value);
        case (idx)
            REG_ENABLE_TICKS:  timing_regs.enable_ticks   = value;
            REG_SETUP_TICKS:   timing_regs.setup_ticks    = value;
            REG_POWERUP_TICKS: timing_regs.powerup_ticks  = value;
            REG_SETTLE_TICKS:  timing_regs.settle_ticks   = value;
            REG_CLEAR_TICKS:   timing_regs.clear_ticks    = value;
            REG_FOUR_LINE:     timing_regs.four_line_mode = value[0];
            default: ;
        endcase
    endfunction

    function automatic int unsigned strobe_ticks();
        return (timing_regs.enable_ticks == '0) ? 1 : int'(timing_regs.enable_ticks);
    endfunction

    function automatic void add_pin(logic rs, logic [3:0] nibble, logic strobe,
                                    int unsigned hold);
        t_out pin;
        pin.register_select = rs;
        pin.read_write      = 1'b0;
        pin.data_nibble     = nibble;
        pin.enable_level    = strobe;
        pin.hold_ticks      = (hold > WAIT_MAX) ? WAIT_MAX : WAIT_BITS'(hold);
        pin.last            = 1'b0;
        expected_pins.push_back(pin);
    endfunction

    function automatic void add_nibble(logic rs, logic [3:0] nibble, int unsigned extra);
        add_pin(rs, nibble, 1'b1, strobe_ticks());
        add_pin(rs, nibble, 1'b0, strobe_ticks() + timing_regs.setup_ticks + extra);
    endfunction

    function automatic void add_byte(logic rs, logic [7:0] value, int unsigned extra);
        add_nibble(rs, value[7:4], 0);
        add_nibble(rs, value[3:0], extra);
    endfunction

    function automatic void predict_burst(t_in req);
        logic [6:0] line_base;
        logic [7:0] ddram_cmd;
        t_out       tail;
        case (req.command)
            CMD_INSTR: add_byte(1'b0, req.byte_value, 0);
            CMD_DATA:  add_byte(1'b1, req.byte_value, 0);
            CMD_GOTO: begin
                line_base = LINE1_BASE;
                if (req.line == 8'd2) begin
                    line_base = LINE2_BASE;
                end else if (req.line == 8'd3 && timing_regs.four_line_mode) begin
                    line_base = LINE3_BASE;
                end else if (req.line == 8'd4 && timing_regs.four_line_mode) begin
                    line_base = LINE4_BASE;
                end
                ddram_cmd = CMD_SET_DDRAM | {1'b0, 7'(line_base + req.column - 8'd1)};
                add_byte(1'b0, ddram_cmd, 0);
            end
            default: begin
                add_pin(1'b0, 4'h0, 1'b0, timing_regs.powerup_ticks);
                add_nibble(1'b0, WAKE_NIBBLE, timing_regs.powerup_ticks);
                add_nibble(1'b0, WAKE_NIBBLE, timing_regs.settle_ticks);
                add_nibble(1'b0, WAKE_NIBBLE, timing_regs.settle_ticks);
                add_nibble(1'b0, MODE4_NIBBLE, timing_regs.settle_ticks);
                add_byte(1'b0, INIT_FUNC_SET, 0);
                add_byte(1'b0, INIT_DISP_ON, 0);
                add_byte(1'b0, INIT_CLEAR, timing_regs.clear_ticks);
                add_byte(1'b0, INIT_ENTRY, 0);
            end
        endcase
        tail = expected_pins.pop_back();
        tail.last = 1'b1;
        expected_pins.push_back(tail);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            mismatch_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            load_reset_timing();
            expected_pins.delete();
        end else begin
            if (i_cfg_we) begin
                write_timing_reg(i_cfg_index, i_cfg_wdata);
            end
            if (i_in_valid && !i_in_stall) begin
                predict_burst(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_pins.size() == 0) begin
                    $display("%0t ns: unexpected pin state beat 0x%0h", $time, i_out_data);
                    mismatch_total++;
                end else begin
                    want = expected_pins.pop_front();
                    check_field("register_select", want.register_select,
                                i_out_data.register_select);
                    check_field("read_write", want.read_write, i_out_data.read_write);
                    check_field("data_nibble", want.data_nibble, i_out_data.data_nibble);
                    check_field("enable_level", want.enable_level, i_out_data.enable_level);
                    check_field("hold_ticks", want.hold_ticks, i_out_data.hold_ticks);
                    check_field("last", want.last, i_out_data.last);
                    beats_matched++;
                end
            end
        end
        o_pending       <= expected_pins.size();
        o_fail_count    <= mismatch_total;
        o_beats_checked <= beats_matched;
    end

endmodule

/* dv/char_lcd_nibble_write_sequencer_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Character LCD nibble write sequencer testbench
// Sends instruction, data, cursor and power-up requests under several timing
// settings with random idling on both sides and one long output hold-off;
// the checker beside the block judges every pin state beat.
// ----------------------------------------------------------------------------

module char_lcd_nibble_write_sequencer_test
    import clnws_pkg::*;
;

    localparam int                    LIMIT_CYCLES    = 200000;
    localparam int                    HOLD_OFF_CYCLES = 300;
    localparam int                    DRAIN_CYCLES    = 40;
    localparam int                    PHASE_ITEMS     = 40;
    localparam logic [CFG_IDX_BITS-1:0] SPARE_REG_LO  = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] SPARE_REG_HI  = 3'd7;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [WAIT_BITS-1:0]    cfg_wdata = '0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    t_in                     in_data   = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    t_out                    out_data;

    int fail_count;
    int pending;
    int beats_checked;

    bit steady           = 1'b0;
    bit hold_off_request = 1'b0;
    int cycle_count      = 0;
    int input_held       = 0;
    int settings_written = 0;
    int cmd_count[4]     = '{0, 0, 0, 0};

    char_lcd_nibble_write_sequencer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    char_lcd_nibble_write_sequencer_checker pin_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_data       (in_data),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_data      (out_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_beats_checked (beats_checked)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
            if (in_valid && in_stall) begin
                input_held++;
            end
        end
        $display("char_lcd_nibble_write_sequencer regression: fail");
        $finish;
    end

    // The receiver stalls at random, or holds off for a long stretch on request.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES - 1) begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
            end else begin
                out_stall <= !steady && ($urandom_range(0, 99) < 31);
            end
        end
    end

    function automatic t_in make_req(t_cmd command, logic [7:0] byte_value,
                                     logic [7:0] line, logic [7:0] column);
        t_in req;
        req.command    = command;
        req.byte_value = byte_value;
        req.line       = line;
        req.column     = column;
        return req;
    endfunction

    function automatic t_in random_request();
        int   pick;
        t_cmd command;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            command = CMD_INSTR;
        end else if (pick < 60) begin
            command = CMD_DATA;
        end else if (pick < 90) begin
            command = CMD_GOTO;
        end else begin
            command = CMD_INIT;
        end
        return make_req(command, 8'($urandom),
                        ($urandom_range(0, 9) < 6) ? 8'($urandom_range(1, 4)) : 8'($urandom),
                        8'($urandom));
    endfunction

    function automatic logic [WAIT_BITS-1:0] random_ticks();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return WAIT_MAX;
            2: return WAIT_BITS'(1);
            5: return WAIT_BITS'($urandom);
            default: return WAIT_BITS'($urandom_range(0, 5000));
        endcase
    endfunction

    task automatic send_request(input t_in req);
        while (!steady && $urandom_range(0, 99) < 31) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_data  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        cmd_count[req.command]++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [WAIT_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    // Writes to the spare indexes must leave every register untouched.
    task automatic apply_settings(input logic [WAIT_BITS-1:0] enable_t,
                                  input logic [WAIT_BITS-1:0] setup_t,
                                  input logic [WAIT_BITS-1:0] powerup_t,
                                  input logic [WAIT_BITS-1:0] settle_t,
                                  input logic [WAIT_BITS-1:0] clear_t,
                                  input logic [WAIT_BITS-1:0] four_line);
        write_reg(REG_ENABLE_TICKS, enable_t);
        write_reg(REG_SETUP_TICKS, setup_t);
        write_reg(REG_POWERUP_TICKS, powerup_t);
        write_reg(REG_SETTLE_TICKS, settle_t);
        write_reg(REG_CLEAR_TICKS, clear_t);
        write_reg(REG_FOUR_LINE, four_line);
        write_reg(SPARE_REG_LO, WAIT_BITS'($urandom));
        write_reg(SPARE_REG_HI, WAIT_BITS'($urandom));
        cfg_we <= 1'b0;
        settings_written++;
    endtask

    initial begin
        t_in directed_reset[$];
        t_in directed_extreme[$];

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_reset = '{
            make_req(CMD_INSTR, 8'h00, 8'h00, 8'h00),
            make_req(CMD_INSTR, 8'hFF, 8'hFF, 8'hFF),
            make_req(CMD_DATA, 8'h00, 8'hFF, 8'h00),
            make_req(CMD_DATA, 8'hFF, 8'h00, 8'hFF),
            make_req(CMD_DATA, 8'hA5, 8'h5A, 8'hC3),
            make_req(CMD_DATA, 8'h5A, 8'hA5, 8'h3C),
            make_req(CMD_GOTO, 8'hFF, 8'd1, 8'd1),
            make_req(CMD_GOTO, 8'h00, 8'd2, 8'd40),
            make_req(CMD_GOTO, 8'h00, 8'd0, 8'd0),
            make_req(CMD_GOTO, 8'h00, 8'd255, 8'd255),
            make_req(CMD_GOTO, 8'h00, 8'd3, 8'd1),
            make_req(CMD_GOTO, 8'h00, 8'd4, 8'd20),
            make_req(CMD_GOTO, 8'h00, 8'd5, 8'd128),
            make_req(CMD_INIT, 8'hFF, 8'hFF, 8'hFF)
        };
        foreach (directed_reset[k]) begin
            send_request(directed_reset[k]);
        end
        wait_idle();

        apply_settings('0, WAIT_MAX, WAIT_MAX, WAIT_MAX, WAIT_MAX, WAIT_MAX);
        directed_extreme = '{
            make_req(CMD_GOTO, 8'h00, 8'd3, 8'd1),
            make_req(CMD_GOTO, 8'h00, 8'd4, 8'd0),
            make_req(CMD_GOTO, 8'h00, 8'd4, 8'd255),
            make_req(CMD_GOTO, 8'h00, 8'd2, 8'd255),
            make_req(CMD_INIT, 8'h00, 8'h00, 8'h00),
            make_req(CMD_DATA, 8'hC3, 8'h00, 8'h00)
        };
        foreach (directed_extreme[k]) begin
            send_request(directed_extreme[k]);
        end
        wait_idle();

        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 0) begin
                apply_settings(WAIT_MAX, '0, '0, '0, '0, 20'hFFFFE);
            end else begin
                apply_settings(random_ticks(), random_ticks(), random_ticks(),
                               random_ticks(), random_ticks(), WAIT_BITS'($urandom));
            end
            steady = (phase == 1);
            if (phase == 2) begin
                hold_off_request = 1'b1;
            end
            repeat (PHASE_ITEMS) begin
                send_request(random_request());
            end
            wait_idle();
        end
        steady = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d instruction, %0d data, %0d cursor and %0d power-up requests",
                 cmd_count[CMD_INSTR], cmd_count[CMD_DATA], cmd_count[CMD_GOTO],
                 cmd_count[CMD_INIT]);
        $display("under %0d timing settings; %0d beats checked, input held off %0d cycles.",
                 settings_written, beats_checked, input_held);
        if (pending != 0) begin
            $display("%0d expected pin state beats never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("char_lcd_nibble_write_sequencer regression: pass");
        end else begin
            $display("char_lcd_nibble_write_sequencer regression: fail");
        end
        $finish;
    end

endmodule
